### hdl/grid_greedy_path_search_defines.svh
// assertion macros for the grid path search block and its checker
// no dependencies; included by the checker file
`ifndef GRID_GREEDY_PATH_SEARCH_DEFINES_SVH
`define GRID_GREEDY_PATH_SEARCH_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define GGPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define GGPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ggps_pkg.sv
// shared types, codes and constants of the grid path search block
// no dependencies; imported by every module of the block
`default_nettype none

package ggps_pkg;

    localparam int GRID_DIM_DEF      = 8;
    localparam int TERRAIN_TYPES_DEF = 16;

    localparam int XW    = 3;   // tile coordinate width
    localparam int TW    = 4;   // terrain code width
    localparam int MW    = 16;  // walkable mask width
    localparam int DW    = 4;   // grid size register width
    localparam int CSTW  = 7;   // path cost width
    localparam int DSTW  = 7;   // squared distance width

    localparam logic [CSTW-1:0] COST_MAX = '1;
    localparam logic [DSTW-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        ST_PATH   = 2'd0,
        ST_NOPATH = 2'd1,
        ST_NOWALK = 2'd2,
        ST_WDONE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        VIS_UNSEEN = 2'd0,
        VIS_OPEN   = 2'd1,
        VIS_CLOSED = 2'd2
    } t_visit;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_GOAL = 2'd1,
        SRC_NODE = 2'd2
    } t_src;

    typedef struct packed {
        t_visit          visit;
        logic [CSTW-1:0] cost;
        logic            has_par;
        logic [XW-1:0]   par_y;
        logic [XW-1:0]   par_x;
    } t_meta;

    localparam t_meta META_INIT = '{visit: VIS_UNSEEN, cost: COST_MAX, has_par: 1'b0,
                                    par_y: '0, par_x: '0};

    typedef struct packed {
        logic    latch;
        logic    cell_wr;
        logic    q_clr;
        logic    rd_ter_s;
        logic    rd_ter_g;
        logic    cap_ws;
        logic    init_s;
        logic    scan_init;
        logic    scan_rd;
        logic    scan_cmp;
        logic    rd_meta_t;
        logic    close_t;
        logic    nb_rd;
        logic    nb_skip;
        logic    nb_upd;
        logic    sh_init;
        logic    sh_rd;
        logic    sh_wr;
        logic    cnt_dec;
        logic    ch_init;
        logic    ch_next;
        logic    emit;
        t_src    emit_src;
        t_status emit_st;
        logic    emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic ws_ok;
        logic same;
        logic i_end;
        logic nb_ok;
        logic nb_last;
        logic is_goal;
        logic sh_end;
        logic cnt_one;
        logic par_ok;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/ggps_dp.sv
// datapath: config registers, terrain/meta/open-list memories, distance compare, result register
// depends on ggps_pkg; driven by ggps_ctrl
`default_nettype none

module ggps_dp
    import ggps_pkg::*;
#(
    parameter int GRID_DIM      = GRID_DIM_DEF,
    parameter int TERRAIN_TYPES = TERRAIN_TYPES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr,
    input  wire logic [1:0]      i_cfg_addr,
    input  wire logic [MW-1:0]   i_cfg_data,
    input  wire logic [XW-1:0]   i_cell_x,
    input  wire logic [XW-1:0]   i_cell_y,
    input  wire logic [TW-1:0]   i_terrain,
    input  wire logic [XW-1:0]   i_start_x,
    input  wire logic [XW-1:0]   i_start_y,
    input  wire logic [XW-1:0]   i_goal_x,
    input  wire logic [XW-1:0]   i_goal_y,
    input  wire logic            i_out_ready,
    input  wire t_dp_cmd         i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic [XW-1:0]        o_path_x,
    output logic [XW-1:0]        o_path_y,
    output t_status              o_status,
    output logic                 o_last
);

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
        if (v == '0) return DW'(1);
        if (v > DW'(GRID_DIM)) return DW'(GRID_DIM);
        return v;
    endfunction

    function automatic logic [XW-1:0] clamp(input logic [XW-1:0] v, input logic [DW-1:0] lim);
        logic [DW-1:0] m1;
        m1 = lim - DW'(1);
        return ({1'b0, v} >= lim) ? m1[XW-1:0] : v;
    endfunction

    function automatic logic [AW-1:0] idx_of(input logic [XW-1:0] x, input logic [XW-1:0] y);
        return AW'(int'(y) * GRID_DIM + int'(x));
    endfunction

    // configuration
    logic [DW-1:0] r_gw, r_gh;
    logic [MW-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= DW'(8);
            r_gh   <= DW'(8);
            r_mask <= '1;
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_gw   <= i_cfg_data[DW-1:0];
                CFG_HEIGHT: r_gh   <= i_cfg_data[DW-1:0];
                CFG_MASK:   r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] w_eff, h_eff;
    assign w_eff = eff_dim(r_gw);
    assign h_eff = eff_dim(r_gh);

    function automatic logic walk(input logic [TW-1:0] t, input logic [MW-1:0] mask);
        return (int'(t) < TERRAIN_TYPES) && mask[t];
    endfunction

    // latched item
    logic [XW-1:0] r_cx, r_cy, r_sx, r_sy, r_gx, r_gy;
    logic [TW-1:0] r_ter;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cx  <= i_cell_x;
            r_cy  <= i_cell_y;
            r_ter <= i_terrain;
            r_sx  <= i_start_x;
            r_sy  <= i_start_y;
            r_gx  <= i_goal_x;
            r_gy  <= i_goal_y;
        end
    end

    logic [XW-1:0] sx_c, sy_c, gx_c, gy_c;
    logic [AW-1:0] s_idx, g_idx;
    assign sx_c  = clamp(r_sx, w_eff);
    assign sy_c  = clamp(r_sy, h_eff);
    assign gx_c  = clamp(r_gx, w_eff);
    assign gy_c  = clamp(r_gy, h_eff);
    assign s_idx = idx_of(sx_c, sy_c);
    assign g_idx = idx_of(gx_c, gy_c);

    // search registers
    logic [XW-1:0]   r_tx, r_ty, r_nx, r_ny;
    logic [AW-1:0]   r_nidx;
    logic [CSTW-1:0] r_tcost;
    logic [DSTW-1:0] r_bd;
    logic [CW-1:0]   r_best, r_i, r_cnt, r_steps;
    logic [1:0]      r_nb;
    logic            r_ws;
    logic [AW-1:0]   t_idx;
    assign t_idx = idx_of(r_tx, r_ty);

    // neighbor order: left, right, up, down
    logic          nb_ok;
    logic [XW-1:0] nb_x, nb_y;
    always_comb begin
        nb_x  = r_tx;
        nb_y  = r_ty;
        nb_ok = 1'b0;
        case (r_nb)
            2'd0: begin
                nb_ok = (r_tx != '0);
                nb_x  = r_tx - XW'(1);
            end
            2'd1: begin
                nb_ok = ({1'b0, r_tx} + DW'(1)) < w_eff;
                nb_x  = r_tx + XW'(1);
            end
            2'd2: begin
                nb_ok = (r_ty != '0);
                nb_y  = r_ty - XW'(1);
            end
            default: begin
                nb_ok = ({1'b0, r_ty} + DW'(1)) < h_eff;
                nb_y  = r_ty + XW'(1);
            end
        endcase
    end
    logic [AW-1:0] nb_idx;
    assign nb_idx = idx_of(nb_x, nb_y);

    // terrain memory, entries never written read as zero
    logic [TW-1:0]    r_ter_mem [CELLS];
    logic [CELLS-1:0] r_ter_vld;
    logic [TW-1:0]    r_ter_q;
    logic             r_ter_qv;
    logic             ter_rd, cell_in;
    logic [AW-1:0]    ter_ra, cell_idx;
    logic [TW-1:0]    ter_eff;

    assign cell_in  = ({1'b0, r_cx} < w_eff) && ({1'b0, r_cy} < h_eff);
    assign cell_idx = idx_of(r_cx, r_cy);
    assign ter_rd   = i_cmd.rd_ter_s | i_cmd.rd_ter_g | i_cmd.nb_rd;
    assign ter_ra   = i_cmd.rd_ter_s ? s_idx : (i_cmd.rd_ter_g ? g_idx : nb_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_wr && cell_in) r_ter_mem[cell_idx] <= r_ter;
        if (ter_rd) r_ter_q <= r_ter_mem[ter_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ter_vld <= '0;
            r_ter_qv  <= 1'b0;
        end else begin
            if (i_cmd.cell_wr && cell_in) r_ter_vld[cell_idx] <= 1'b1;
            if (ter_rd) r_ter_qv <= r_ter_vld[ter_ra];
        end
    end
    assign ter_eff = r_ter_qv ? r_ter_q : '0;

    // parent / cost / visit memory, entries untouched this query read as META_INIT
    t_meta            r_meta_mem [CELLS];
    logic [CELLS-1:0] r_meta_vld;
    t_meta            r_mq;
    logic             r_mqv;
    t_meta            m_eff, m_wd, m_upd;
    logic             m_we, m_rd, nb_walk, nb_new;
    logic [AW-1:0]    m_wa, m_ra;
    logic [CSTW:0]    c_new;

    assign m_eff   = r_mqv ? r_mq : META_INIT;
    assign nb_walk = walk(ter_eff, r_mask);
    assign nb_new  = (m_eff.visit == VIS_UNSEEN) && (r_cnt < CW'(CELLS));
    assign c_new   = {1'b0, r_tcost} + (CSTW+1)'(1);

    always_comb begin
        m_upd = m_eff;
        if (nb_new) m_upd.visit = VIS_OPEN;
        if (c_new < {1'b0, m_eff.cost}) begin
            m_upd.cost    = c_new[CSTW-1:0];
            m_upd.has_par = 1'b1;
            m_upd.par_x   = r_tx;
            m_upd.par_y   = r_ty;
        end
    end

    always_comb begin
        m_we = 1'b0;
        m_wa = r_nidx;
        m_wd = m_upd;
        if (i_cmd.init_s) begin
            m_we      = 1'b1;
            m_wa      = s_idx;
            m_wd      = META_INIT;
            m_wd.cost = '0;
        end else if (i_cmd.close_t) begin
            m_we       = 1'b1;
            m_wa       = t_idx;
            m_wd       = m_eff;
            m_wd.visit = VIS_CLOSED;
        end else if (i_cmd.nb_upd) begin
            m_we = nb_walk;
        end
    end

    assign m_rd = i_cmd.rd_meta_t | i_cmd.nb_rd;
    assign m_ra = i_cmd.nb_rd ? nb_idx : t_idx;

    always_ff @(posedge i_clk) begin
        if (m_we) r_meta_mem[m_wa] <= m_wd;
        if (m_rd) r_mq <= r_meta_mem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
            r_mqv      <= 1'b0;
        end else begin
            if (i_cmd.q_clr) r_meta_vld <= '0;
            else if (m_we)   r_meta_vld[m_wa] <= 1'b1;
            if (m_rd) r_mqv <= r_meta_vld[m_ra];
        end
    end

    // open list memory, holds {y, x} in insertion order
    logic [2*XW-1:0] r_open_mem [CELLS];
    logic [2*XW-1:0] r_oq, o_wd;
    logic            o_we, o_rd, append;
    logic [AW-1:0]   o_wa, o_ra;
    logic [CW-1:0]   i_nxt;

    assign append = i_cmd.nb_upd && nb_walk && nb_new;
    assign i_nxt  = r_i + CW'(1);

    always_comb begin
        o_we = 1'b0;
        o_wa = r_i[AW-1:0];
        o_wd = r_oq;
        if (i_cmd.init_s) begin
            o_we = 1'b1;
            o_wa = '0;
            o_wd = {sy_c, sx_c};
        end else if (append) begin
            o_we = 1'b1;
            o_wa = r_cnt[AW-1:0];
            o_wd = {r_ny, r_nx};
        end else if (i_cmd.sh_wr) begin
            o_we = 1'b1;
        end
    end

    assign o_rd = i_cmd.scan_rd | i_cmd.sh_rd;
    assign o_ra = i_cmd.sh_rd ? i_nxt[AW-1:0] : r_i[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (o_we) r_open_mem[o_wa] <= o_wd;
        if (o_rd) r_oq <= r_open_mem[o_ra];
    end

    // squared distance of the open entry just read
    logic [XW-1:0]   ox, oy, adx, ady;
    logic [DSTW-1:0] adx_w, ady_w;
    logic [DSTW-1:0] sq_dist;
    assign ox      = r_oq[XW-1:0];
    assign oy      = r_oq[2*XW-1:XW];
    assign adx     = (ox > gx_c) ? (ox - gx_c) : (gx_c - ox);
    assign ady     = (oy > gy_c) ? (oy - gy_c) : (gy_c - oy);
    assign adx_w   = {{(DSTW-XW){1'b0}}, adx};
    assign ady_w   = {{(DSTW-XW){1'b0}}, ady};
    assign sq_dist = (adx_w * adx_w) + (ady_w * ady_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.q_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.init_s) begin
            r_cnt <= CW'(1);
        end else if (append) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_ws) r_ws <= walk(ter_eff, r_mask);
        if (i_cmd.scan_init) begin
            r_i  <= '0;
            r_bd <= DIST_MAX;
        end else if (i_cmd.scan_cmp) begin
            r_i <= i_nxt;
            if (sq_dist < r_bd) begin
                r_bd   <= sq_dist;
                r_best <= r_i;
                r_tx   <= ox;
                r_ty   <= oy;
            end
        end else if (i_cmd.sh_init) begin
            r_i <= r_best;
        end else if (i_cmd.sh_wr) begin
            r_i <= i_nxt;
        end
        if (i_cmd.close_t) begin
            r_tcost <= m_eff.cost;
            r_nb    <= 2'd0;
        end else if (i_cmd.nb_skip || i_cmd.nb_upd) begin
            r_nb <= r_nb + 2'd1;
        end
        if (i_cmd.nb_rd) begin
            r_nx   <= nb_x;
            r_ny   <= nb_y;
            r_nidx <= nb_idx;
        end
        if (i_cmd.ch_init) begin
            r_steps <= '0;
        end else if (i_cmd.ch_next) begin
            r_steps <= r_steps + CW'(1);
            r_tx    <= m_eff.par_x;
            r_ty    <= m_eff.par_y;
        end
    end

    // result register
    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= i_cmd.emit_st;
            o_last   <= i_cmd.emit_last;
            case (i_cmd.emit_src)
                SRC_GOAL: begin
                    o_path_x <= gx_c;
                    o_path_y <= gy_c;
                end
                SRC_NODE: begin
                    o_path_x <= r_tx;
                    o_path_y <= r_ty;
                end
                default: begin
                    o_path_x <= '0;
                    o_path_y <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.ws_ok    = r_ws && walk(ter_eff, r_mask);
        o_sts.same     = (s_idx == g_idx);
        o_sts.i_end    = (r_i == r_cnt);
        o_sts.nb_ok    = nb_ok;
        o_sts.nb_last  = (r_nb == 2'd3);
        o_sts.is_goal  = (r_tx == gx_c) && (r_ty == gy_c);
        o_sts.sh_end   = (i_nxt >= r_cnt);
        o_sts.cnt_one  = (r_cnt == CW'(1));
        o_sts.par_ok   = m_eff.has_par && (({1'b0, r_steps} + (CW+1)'(1)) < (CW+1)'(CELLS));
        o_sts.out_free = out_free;
    end

endmodule

`default_nettype wire

### hdl/ggps_ctrl.sv
// controller state machine sequencing cell writes, search loop, removal and path readout
// depends on ggps_pkg; commands ggps_dp
`default_nettype none

module ggps_ctrl
    import ggps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_cmd,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_WR, S_QCLR, S_QRDG, S_QCHK, S_SRD, S_SCMP, S_SDONE, S_ERDT,
        S_NSEL, S_NUPD, S_AFTER, S_SHRD, S_SHWR, S_CRD, S_CCHK, S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_status r_fin, n_fin;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_in_cmd ? S_QCLR : S_WR;
                end
            end
            S_WR: begin
                o_cmd.cell_wr = 1'b1;
                n_fin   = ST_WDONE;
                n_state = S_FIN;
            end
            S_QCLR: begin
                o_cmd.q_clr    = 1'b1;
                o_cmd.rd_ter_s = 1'b1;
                n_state = S_QRDG;
            end
            S_QRDG: begin
                o_cmd.cap_ws   = 1'b1;
                o_cmd.rd_ter_g = 1'b1;
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (!i_sts.ws_ok) begin
                    n_fin   = ST_NOWALK;
                    n_state = S_FIN;
                end else if (i_sts.same) begin
                    n_fin   = ST_PATH;
                    n_state = S_FIN;
                end else begin
                    o_cmd.init_s    = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (i_sts.i_end) begin
                    n_state = S_SDONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = S_SRD;
            end
            S_SDONE: begin
                o_cmd.rd_meta_t = 1'b1;
                n_state = S_ERDT;
            end
            S_ERDT: begin
                o_cmd.close_t = 1'b1;
                n_state = S_NSEL;
            end
            S_NSEL: begin
                if (i_sts.nb_ok) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state = S_NUPD;
                end else begin
                    o_cmd.nb_skip = 1'b1;
                    if (i_sts.nb_last) n_state = S_AFTER;
                end
            end
            S_NUPD: begin
                o_cmd.nb_upd = 1'b1;
                n_state = i_sts.nb_last ? S_AFTER : S_NSEL;
            end
            S_AFTER: begin
                if (i_sts.is_goal) begin
                    o_cmd.ch_init   = 1'b1;
                    o_cmd.rd_meta_t = 1'b1;
                    n_state = S_CCHK;
                end else begin
                    o_cmd.sh_init = 1'b1;
                    n_state = S_SHRD;
                end
            end
            // close the gap left by the expanded entry
            S_SHRD: begin
                if (i_sts.sh_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    if (i_sts.cnt_one) begin
                        n_fin   = ST_NOPATH;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SRD;
                    end
                end else begin
                    o_cmd.sh_rd = 1'b1;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state = S_SHRD;
            end
            S_CRD: begin
                o_cmd.rd_meta_t = 1'b1;
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_NODE;
                    o_cmd.emit_st  = ST_PATH;
                    if (i_sts.par_ok) begin
                        o_cmd.ch_next = 1'b1;
                        n_state = S_CRD;
                    end else begin
                        o_cmd.emit_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = (r_fin == ST_PATH) ? SRC_GOAL : SRC_ZERO;
                    o_cmd.emit_st   = r_fin;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= ST_PATH;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

`default_nettype wire

### hdl/grid_greedy_path_search.sv
// A cell write gives its result after the transaction; a query on a non-walkable or identical
// tile pair gives it without a search. A search scans the open-list entries on each expansion,
// then handles the neighbors and moves the later entries up on removal, and at the end gives the
// path tile by tile. One item at a time. Synchronous active-low reset: config 8/8/ffff, terrain
// reads as zero.
`default_nettype none

module grid_greedy_path_search
    import ggps_pkg::*;
#(
    parameter int GRID_DIM      = GRID_DIM_DEF,
    parameter int TERRAIN_TYPES = TERRAIN_TYPES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_addr,
    input  wire logic [MW-1:0] i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // cell_x[2:0] cell_y[5:3] terrain[9:6] start_x[12:10] start_y[15:13]
    // goal_x[18:16] goal_y[21:19] zero[23:22]
    input  wire logic [23:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic          s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // path_x[2:0] path_y[5:3] zero[7:6]
    output logic [7:0]         m_axis_tdata,
    // status[1:0]
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [XW-1:0] px, py;
    t_status       st;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {2'b00, py, px};
    assign m_axis_tuser = st;

    ggps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ggps_dp #(
        .GRID_DIM      (GRID_DIM),
        .TERRAIN_TYPES (TERRAIN_TYPES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cell_x    (s_axis_tdata[2:0]),
        .i_cell_y    (s_axis_tdata[5:3]),
        .i_terrain   (s_axis_tdata[9:6]),
        .i_start_x   (s_axis_tdata[12:10]),
        .i_start_y   (s_axis_tdata[15:13]),
        .i_goal_x    (s_axis_tdata[18:16]),
        .i_goal_y    (s_axis_tdata[21:19]),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_path_x    (px),
        .o_path_y    (py),
        .o_status    (st),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hdl/ggps_chk.sv
// port-level checker for the grid path search block, bound to the top level
// depends on ggps_pkg and grid_greedy_path_search_defines.svh
`default_nettype none
`include "grid_greedy_path_search_defines.svh"

module ggps_chk
    import ggps_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    `GGPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    `GGPS_ASSERT_NOW(a_single_result, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_PATH), m_axis_tlast && (m_axis_tdata == 8'd0), "non-path result must be last with zero tile")

    `GGPS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")

endmodule

bind grid_greedy_path_search ggps_chk u_ggps_chk (.*);

`default_nettype wire

### dv/grid_greedy_path_search_tb.sv
// testbench for the grid path search block: random terrain writes and path queries
// with a scoreboard class holding its own grid search; depends on ggps_pkg and the rtl
`default_nettype none

module grid_greedy_path_search_tb;
    import ggps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        t_status    st;
        logic       lst;
    } t_tile_res;

    class path_scoreboard;
        logic [3:0]  cfg_w, cfg_h;
        logic [15:0] mask;
        logic [3:0]  terrain_map[64];
        logic [6:0]  parent[64];
        logic [6:0]  cost[64];
        t_visit      mark[64];
        logic [5:0]  open_q[64];
        int          open_n;
        t_tile_res   pending[$];
        int          errors;

        function void reset_state();
            cfg_w = 4'd8; cfg_h = 4'd8; mask = 16'hffff;
            foreach (terrain_map[i]) terrain_map[i] = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_WIDTH:  cfg_w = v[3:0];
                CFG_HEIGHT: cfg_h = v[3:0];
                CFG_MASK:   mask = v;
                default: ;
            endcase
        endfunction

        function int dim_of(logic [3:0] v);
            if (v == 0) return 1;
            if (v > 8) return 8;
            return int'(v);
        endfunction

        function bit can_walk(logic [3:0] t);
            return mask[t];
        endfunction

        function void push(logic [2:0] x, logic [2:0] y, t_status st, logic l);
            t_tile_res r;
            r.x = x; r.y = y; r.st = st; r.lst = l;
            pending = {pending, r};
        endfunction

        function int sqdist(int idx, int gx, int gy);
            int dx, dy;
            dx = idx % 8 - gx;
            dy = idx / 8 - gy;
            return dx * dx + dy * dy;
        endfunction

        function void relax(int nx, int ny, int from);
            int idx;
            idx = ny * 8 + nx;
            if (!can_walk(terrain_map[idx])) return;
            if (mark[idx] == VIS_UNSEEN && open_n < 64) begin
                open_q[open_n] = 6'(idx);
                open_n++;
                mark[idx] = VIS_OPEN;
            end
            if (int'(cost[from]) + 1 < int'(cost[idx])) begin
                parent[idx] = 7'(from);
                cost[idx] = 7'(int'(cost[from]) + 1);
            end
        endfunction

        // note one accepted input transaction and queue its expected results
        function void note_item(logic cmd, logic [23:0] d);
            int w, h, sx, sy, gx, gy, s, g, best, bd, dd, t, tx, ty, steps;
            w = dim_of(cfg_w);
            h = dim_of(cfg_h);
            if (!cmd) begin
                if (d[2:0] < w && d[5:3] < h) terrain_map[d[5:3] * 8 + d[2:0]] = d[9:6];
                push(3'd0, 3'd0, ST_WDONE, 1'b1);
                return;
            end
            foreach (parent[i]) begin
                parent[i] = 7'd127; cost[i] = 7'd127; mark[i] = VIS_UNSEEN; open_q[i] = '0;
            end
            open_n = 0;
            sx = d[12:10] >= w ? w - 1 : d[12:10];
            sy = d[15:13] >= h ? h - 1 : d[15:13];
            gx = d[18:16] >= w ? w - 1 : d[18:16];
            gy = d[21:19] >= h ? h - 1 : d[21:19];
            s = sy * 8 + sx;
            g = gy * 8 + gx;
            if (!can_walk(terrain_map[s]) || !can_walk(terrain_map[g])) begin
                push(3'd0, 3'd0, ST_NOWALK, 1'b1);
                return;
            end
            if (s == g) begin
                push(3'(gx), 3'(gy), ST_PATH, 1'b1);
                return;
            end
            cost[s] = 7'd0;
            open_q[0] = 6'(s);
            open_n = 1;
            while (open_n > 0) begin
                best = 0;
                bd = sqdist(int'(open_q[0]), gx, gy);
                for (int i = 1; i < open_n; i++) begin
                    dd = sqdist(int'(open_q[i]), gx, gy);
                    if (bd > dd) begin
                        best = i; bd = dd;
                    end
                end
                t = int'(open_q[best]);
                tx = t % 8; ty = t / 8;
                mark[t] = VIS_CLOSED;
                if (tx >= 1) relax(tx - 1, ty, t);
                if (tx + 1 < w) relax(tx + 1, ty, t);
                if (ty >= 1) relax(tx, ty - 1, t);
                if (ty + 1 < h) relax(tx, ty + 1, t);
                if (t == g) begin
                    steps = 0;
                    while (parent[t] != 7'd127 && steps + 1 < 64) begin
                        push(3'(t % 8), 3'(t / 8), ST_PATH, 1'b0);
                        t = int'(parent[t]);
                        steps++;
                    end
                    push(3'(t % 8), 3'(t / 8), ST_PATH, 1'b1);
                    return;
                end
                for (int i = best; i + 1 < open_n; i++) open_q[i] = open_q[i + 1];
                open_n--;
            end
            push(3'd0, 3'd0, ST_NOPATH, 1'b1);
        endfunction

        function void check_result(logic [7:0] d, logic [1:0] st, logic l);
            t_tile_res e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual x=%0d y=%0d st=%0d last=%0d",
                         $time, d[2:0], d[5:3], st, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] != e.x || d[5:3] != e.y || st != e.st || l != e.lst || d[7:6] != 0) begin
                $display("%0t mismatch: expected x=%0d y=%0d st=%0d last=%0d,",
                         $time, e.x, e.y, e.st, e.lst,
                         " actual x=%0d y=%0d st=%0d last=%0d pad=%0d",
                         d[2:0], d[5:3], st, l, d[7:6]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = 0;
    logic [15:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    grid_greedy_path_search dut (.*);

    always #5 i_clk = ~i_clk;

    path_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 40_000_000;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: sample at rising edge, change ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid drops at the falling edge after a transaction and rises at a later one
    task automatic send_item(logic cmd, logic [23:0] d);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(cmd, d);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic write_cell(int x, int y, int t);
        send_item(0, {14'd0, t[3:0], y[2:0], x[2:0]});
    endtask

    task automatic query(int sx, int sy, int gx, int gy);
        send_item(1, {2'd0, gy[2:0], gx[2:0], sy[2:0], sx[2:0], 4'd0, 6'd0});
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_item(int qpct);
        logic [23:0] d;
        d = 24'($urandom());
        d[23:22] = 0;
        if ($urandom_range(99) < qpct) send_item(1, d);
        else send_item(0, d);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) random_item(45);
    endtask

    initial begin
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: trivial cases and a walled maze on the full grid
        query(0, 0, 0, 0);
        query(7, 7, 0, 0);
        query(0, 0, 7, 7);
        write_cell(3, 0, 15);
        write_cell(3, 1, 15);
        write_cell(3, 2, 15);
        write_cell(3, 3, 15);
        write_cell(7, 7, 15);
        drain();
        write_reg(CFG_MASK, 16'h7fff);
        query(0, 0, 6, 0);
        query(0, 0, 7, 7);
        query(7, 7, 0, 0);
        write_cell(3, 4, 15);
        write_cell(3, 5, 15);
        write_cell(3, 6, 15);
        write_cell(3, 7, 15);
        query(1, 1, 6, 6);
        drain();
        // out-of-range sizes clamp; writes outside the grid are dropped
        write_reg(CFG_WIDTH, 0);
        write_reg(CFG_HEIGHT, 15);
        write_cell(5, 5, 15);
        query(7, 0, 7, 6);
        query(2, 2, 2, 2);
        drain();
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 1);
        query(0, 0, 7, 7);
        write_cell(1, 0, 9);
        drain();
        write_reg(CFG_MASK, 16'hfdff);
        query(0, 0, 1, 0);
        drain();

        // random phases across settings and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 11; recv_idle_pct = 47;
            end else if (ph < 4) begin
                send_idle_pct = 47; recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            write_reg(CFG_WIDTH, ph == 5 ? 16'd8 : 16'($urandom_range(1, 8)));
            write_reg(CFG_HEIGHT, ph == 4 ? 16'd1 : 16'($urandom_range(1, 8)));
            write_reg(CFG_MASK, ph == 0 ? 16'h0000 :
                      (ph == 5 ? 16'hffff : 16'($urandom() | 32'h00ff)));
            if (ph == 3) begin
                // long receiver stall while the sender keeps offering writes
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 8; i++) random_item(0);
                join
            end
            random_phase(ph == 0 ? 10 : 22);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
